>>> hdl/tegp_pkg.sv
package tegp_pkg;

    localparam int MAX_EDGES   = 16;
    localparam int TIME_W      = 16;
    localparam int IDX_W       = $clog2(MAX_EDGES);
    localparam int ACTION_W    = 2;
    localparam int SLOT_W      = 4;
    localparam int EDGE_CNT_W  = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [TIME_W-1:0]     TOP_COUNT_RESET  = TIME_W'(180);
    localparam logic [EDGE_CNT_W-1:0] EDGE_COUNT_RESET = EDGE_CNT_W'(1);
    localparam logic [TIME_W-1:0]     TIME_MAX         = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK    = 2'd0,
        ACT_TRIGGER = 2'd1,
        ACT_LOAD    = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP_COUNT  = 1'd0,
        REG_EDGE_COUNT = 1'd1
    } reg_index_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   entry_index;
        logic [TIME_W-1:0]   entry_time;
    } item_t;

    typedef struct packed {
        logic [TIME_W-1:0]     top_count;
        logic [EDGE_CNT_W-1:0] edge_count;
    } cfg_t;

endpackage

>>> hdl/tegp_if.sv
interface tegp_item_if;
    logic                            valid;
    logic                            ready;
    logic [tegp_pkg::ACTION_W-1:0]   action;
    logic [tegp_pkg::SLOT_W-1:0]     entry_index;
    logic [tegp_pkg::TIME_W-1:0]     entry_time;

    modport source (output valid, action, entry_index, entry_time, input ready);
    modport sink   (input valid, action, entry_index, entry_time, output ready);
endinterface

interface tegp_result_if;
    logic valid;
    logic ready;
    logic pulse_level;
    logic blink_level;
    logic is_running;
    logic run_ended;

    modport source (output valid, pulse_level, blink_level, is_running, run_ended,
                    input ready);
    modport sink   (input valid, pulse_level, blink_level, is_running, run_ended,
                    output ready);
endinterface

>>> hdl/tegp_cfg_regs.sv
module tegp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tegp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tegp_pkg::CFG_DATA_W-1:0] cfg_data,
    output tegp_pkg::cfg_t                 cfg
);
    import tegp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.top_count  <= TOP_COUNT_RESET;
            cfg_reg.edge_count <= EDGE_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_TOP_COUNT:  cfg_reg.top_count  <= TIME_W'(cfg_data);
                REG_EDGE_COUNT: cfg_reg.edge_count <= EDGE_CNT_W'(cfg_data);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/tegp_in_reg.sv
module tegp_in_reg (
    input  logic            clk,
    input  logic            rst_n,
    tegp_item_if.sink       items,
    input  logic            pop,
    output logic            item_valid,
    output tegp_pkg::item_t item
);
    import tegp_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    logic  load;

    // refill in the same cycle the held transaction moves on
    assign items.ready = !valid_reg || pop;
    assign load        = items.valid && items.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.action      <= items.action;
            item_reg.entry_index <= items.entry_index;
            item_reg.entry_time  <= items.entry_time;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> hdl/tegp_engine.sv
module tegp_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  tegp_pkg::cfg_t  cfg,
    input  logic            item_valid,
    input  tegp_pkg::item_t item,
    output logic            pop,
    tegp_result_if.source   results
);
    import tegp_pkg::*;

    logic [TIME_W-1:0]     edge_times [MAX_EDGES];

    logic [TIME_W-1:0]     tick_count_reg, tick_count_next;
    logic [IDX_W-1:0]      edge_index_reg, edge_index_next;
    logic                  level_bit_reg, level_bit_next;
    logic                  flip_bit_reg, flip_bit_next;
    logic                  running_reg, running_next;
    logic                  pulse_out_reg, pulse_out_next;
    logic                  blink_out_reg, blink_out_next;
    logic                  ended_reg, ended_next;
    logic                  out_valid_reg;

    logic [EDGE_CNT_W-1:0] last_index;
    logic                  table_we;
    logic [TIME_W-1:0]     count_inc;

    assign pop = item_valid && (!out_valid_reg || results.ready);

    // highest usable table index, edge count clamped to 1..MAX_EDGES
    always_comb
    begin
        if (cfg.edge_count == '0)
        begin
            last_index = '0;
        end
        else if (32'(cfg.edge_count) > MAX_EDGES)
        begin
            last_index = EDGE_CNT_W'(MAX_EDGES - 1);
        end
        else
        begin
            last_index = cfg.edge_count - EDGE_CNT_W'(1);
        end
    end

    assign count_inc = (tick_count_reg == TIME_MAX) ? tick_count_reg
                                                    : tick_count_reg + TIME_W'(1);

    assign table_we = pop && (action_t'(item.action) == ACT_LOAD) && !running_reg
                      && (32'(item.entry_index) < MAX_EDGES);

    always_comb
    begin
        tick_count_next = tick_count_reg;
        edge_index_next = edge_index_reg;
        level_bit_next  = level_bit_reg;
        flip_bit_next   = flip_bit_reg;
        running_next    = running_reg;
        pulse_out_next  = pulse_out_reg;
        blink_out_next  = blink_out_reg;
        ended_next      = 1'b0;

        case (action_t'(item.action))
            ACT_TICK:
            begin
                if (running_reg)
                begin
                    blink_out_next  = flip_bit_reg;
                    flip_bit_next   = !flip_bit_reg;
                    tick_count_next = count_inc;
                    if (count_inc >= edge_times[edge_index_reg])
                    begin
                        pulse_out_next = level_bit_reg;
                        if (EDGE_CNT_W'(edge_index_reg) < last_index)
                        begin
                            edge_index_next = edge_index_reg + IDX_W'(1);
                            level_bit_next  = !level_bit_reg;
                        end
                    end
                    if (count_inc > cfg.top_count)
                    begin
                        // counter restarts at one, not zero; flip bit carries over
                        running_next    = 1'b0;
                        tick_count_next = TIME_W'(1);
                        edge_index_next = '0;
                        level_bit_next  = 1'b0;
                        pulse_out_next  = 1'b0;
                        blink_out_next  = 1'b0;
                        ended_next      = 1'b1;
                    end
                end
            end
            ACT_TRIGGER:
            begin
                pulse_out_next = 1'b0;
                if (!running_reg)
                begin
                    blink_out_next = 1'b1;
                    running_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            edge_index_reg <= '0;
            level_bit_reg  <= 1'b0;
            flip_bit_reg   <= 1'b0;
            running_reg    <= 1'b0;
            pulse_out_reg  <= 1'b0;
            blink_out_reg  <= 1'b0;
            ended_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                tick_count_reg <= tick_count_next;
                edge_index_reg <= edge_index_next;
                level_bit_reg  <= level_bit_next;
                flip_bit_reg   <= flip_bit_next;
                running_reg    <= running_next;
                pulse_out_reg  <= pulse_out_next;
                blink_out_reg  <= blink_out_next;
                ended_reg      <= ended_next;
                out_valid_reg  <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            edge_times[IDX_W'(item.entry_index)] <= item.entry_time;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.pulse_level = pulse_out_reg;
    assign results.blink_level = blink_out_reg;
    assign results.is_running  = running_reg;
    assign results.run_ended   = ended_reg;

endmodule

>>> hdl/triggered_edge_list_pulse_generator.sv
// Triggered edge-list pulse generator. Every input transaction (tick, trigger or table
// load) yields exactly one result transaction carrying the pulse and blink levels, the
// running flag and a run-ended flag. One transaction is taken per clock unless results
// back-pressure stalls: it is held in an input register, evaluated against the run state
// in a single step and lands in the result register, and the next input can follow
// immediately. The edge time table is flop-based with no reset; load every entry a run
// will reach before triggering. The user must write configuration (top count, edge count)
// through cfg_we/cfg_index/cfg_data while the block is quiescent; it does not enforce it.
module triggered_edge_list_pulse_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    tegp_item_if.sink                       items,
    tegp_result_if.source                   results,
    input  logic                            cfg_we,
    input  logic [tegp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tegp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tegp_pkg::*;

    cfg_t  cfg;
    item_t item;
    logic  item_valid;
    logic  pop;

    tegp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tegp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .items      (items),
        .pop        (pop),
        .item_valid (item_valid),
        .item       (item)
    );

    tegp_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .pop        (pop),
        .results    (results)
    );

endmodule
